// ===== src/scs_pkg.sv =====
// Shared types and constants for the source splice and comment strip block.
// Used by the core, the result queue and the top level; no dependencies.
`default_nettype none

package scs_pkg;

    localparam int RES_MAX = 3;
    localparam int CNT_W   = $clog2(RES_MAX + 1);

    typedef struct packed {
        logic [CNT_W-1:0]           cnt;
        logic [RES_MAX-1:0][7:0]    bytes;
        logic                       final_mark;
    } t_group;

    typedef struct packed {
        logic   push;
        t_group group;
    } t_push;

endpackage

`default_nettype wire

// ===== src/scs_core.sv =====
// Input register, splice and strip state, and the per-byte update logic.
// Depends on scs_pkg for the result group types.
`default_nettype none

module scs_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic [7:0]     i_text_byte,
    input  wire logic           i_final_byte,
    output logic                o_in_stall,
    input  wire logic           i_q_ready,
    output scs_pkg::t_push      o_push
);

    localparam logic [7:0] C_BSLASH = 8'h5c;
    localparam logic [7:0] C_NL     = 8'h0a;
    localparam logic [7:0] C_SLASH  = 8'h2f;
    localparam logic [7:0] C_STAR   = 8'h2a;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_VTAB   = 8'h0b;

    typedef enum logic [4:0] {
        M_NORMAL = 5'b00001,
        M_LEAD   = 5'b00010,
        M_LINE   = 5'b00100,
        M_BLOCK  = 5'b01000,
        M_STAR   = 5'b10000
    } t_mode;

    typedef struct packed {
        t_mode          mode;
        logic [7:0]     held_char;
        logic           held_valid;
        logic [1:0]     space_run;
    } t_st;

    typedef struct packed {
        t_st                                        st;
        logic [scs_pkg::CNT_W-1:0]                  cnt;
        logic [scs_pkg::RES_MAX-1:0][7:0]           bytes;
    } t_work;

    function automatic logic is_ws(logic [7:0] c);
        return (c == C_SPACE) || (c == C_TAB) || (c == C_VTAB);
    endfunction

    function automatic t_work put(t_work w, logic [7:0] c);
        t_work r;
        r = w;
        if (w.cnt != scs_pkg::CNT_W'(scs_pkg::RES_MAX)) begin
            r.bytes[w.cnt] = c;
            r.cnt          = w.cnt + scs_pkg::CNT_W'(1);
        end
        return r;
    endfunction

    function automatic t_work flush_hold(t_work w);
        t_work r;
        r = w;
        if (w.st.held_valid) begin
            r = put(r, (w.st.space_run >= 2'd2) ? C_SPACE : w.st.held_char);
        end
        r.st.held_valid = 1'b0;
        r.st.space_run  = 2'd0;
        r.st.held_char  = 8'h00;
        return r;
    endfunction

    function automatic t_work normal_byte(t_work w, logic [7:0] c);
        t_work r;
        r = w;
        if (r.st.held_valid && (r.st.space_run == 2'd0)) begin
            if (c == C_SLASH) begin
                r.st.held_valid = 1'b0;
                r.st.held_char  = 8'h00;
                r.st.mode       = M_LINE;
                return r;
            end
            if (c == C_STAR) begin
                r.st.held_valid = 1'b0;
                r.st.held_char  = 8'h00;
                r.st.mode       = M_BLOCK;
                return r;
            end
            r = flush_hold(r);
        end
        if (is_ws(c)) begin
            if (r.st.held_valid) begin
                if (r.st.space_run < 2'd2) begin
                    r.st.space_run = r.st.space_run + 2'd1;
                end
            end else begin
                r.st.held_char  = c;
                r.st.held_valid = 1'b1;
                r.st.space_run  = 2'd1;
            end
            return r;
        end
        r = flush_hold(r);
        if (c == C_SLASH) begin
            r.st.held_char  = c;
            r.st.held_valid = 1'b1;
            r.st.space_run  = 2'd0;
        end else if (c == C_NL) begin
            r = put(r, c);
            r.st.mode = M_LEAD;
        end else begin
            r = put(r, c);
        end
        return r;
    endfunction

    function automatic t_work stage_two(t_work w, logic [7:0] c);
        t_work r;
        r = w;
        unique case (w.st.mode)
            M_LEAD: begin
                if (is_ws(c)) begin
                    return r;
                end
                if (c == C_NL) begin
                    return put(r, c);
                end
                r.st.mode = M_NORMAL;
                r = normal_byte(r, c);
            end
            M_LINE: begin
                if (c == C_NL) begin
                    r = put(r, c);
                    r.st.mode = M_LEAD;
                end
            end
            M_BLOCK: begin
                if (c == C_STAR) begin
                    r.st.mode = M_STAR;
                end
            end
            M_STAR: begin
                if (c == C_SLASH) begin
                    r.st.mode = M_NORMAL;
                end else if (c != C_STAR) begin
                    r.st.mode = M_BLOCK;
                end
            end
            default: begin
                r.st.mode = M_NORMAL;
                r = normal_byte(r, c);
            end
        endcase
        return r;
    endfunction

    logic           r_in_valid;
    logic [7:0]     r_in_byte;
    logic           r_in_final;
    logic           r_bs;
    t_st            r_st;

    logic           n_bs;
    t_st            n_st;
    t_work          w;
    logic           process;
    logic           accept;

    assign process    = r_in_valid && i_q_ready;
    assign o_in_stall = r_in_valid && !i_q_ready;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        w.st    = r_st;
        w.cnt   = '0;
        w.bytes = '0;
        n_bs    = r_bs;
        if (r_bs) begin
            n_bs = 1'b0;
            if (r_in_byte != C_NL) begin
                w = stage_two(w, C_BSLASH);
                if (r_in_byte == C_BSLASH) begin
                    n_bs = 1'b1;
                end else begin
                    w = stage_two(w, r_in_byte);
                end
            end
        end else if (r_in_byte == C_BSLASH) begin
            n_bs = 1'b1;
        end else begin
            w = stage_two(w, r_in_byte);
        end
        if (r_in_final) begin
            if (n_bs) begin
                w = stage_two(w, C_BSLASH);
            end
            if (w.st.mode == M_NORMAL) begin
                w = flush_hold(w);
            end
            n_bs               = 1'b0;
            n_st.mode          = M_NORMAL;
            n_st.held_char     = 8'h00;
            n_st.held_valid    = 1'b0;
            n_st.space_run     = 2'd0;
        end else begin
            n_st = w.st;
        end
    end

    assign o_push.push             = process && ((w.cnt != '0) || r_in_final);
    assign o_push.group.cnt        = w.cnt;
    assign o_push.group.bytes      = w.bytes;
    assign o_push.group.final_mark = r_in_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_bs             <= 1'b0;
            r_st.mode        <= M_NORMAL;
            r_st.held_char   <= 8'h00;
            r_st.held_valid  <= 1'b0;
            r_st.space_run   <= 2'd0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
            if (process) begin
                r_bs <= n_bs;
                r_st <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte  <= i_text_byte;
            r_in_final <= i_final_byte;
        end
    end

endmodule

`default_nettype wire

// ===== src/scs_outq.sv =====
// Two-entry queue of result groups and the serializer that sends one result
// per output transaction. Depends on scs_pkg for the group types.
`default_nettype none

module scs_outq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire scs_pkg::t_push i_push,
    output logic                o_q_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_has_byte,
    output logic                o_end_of_text
);

    scs_pkg::t_group                r_entries [2];
    logic                           r_head;
    logic                           r_tail;
    logic [1:0]                     r_count;
    logic [scs_pkg::CNT_W-1:0]      r_idx;

    scs_pkg::t_group                head_g;
    logic                           last;
    logic                           out_take;
    logic                           pop;
    logic                           push;

    assign head_g      = r_entries[r_head];
    assign o_q_ready   = (r_count != 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign o_has_byte  = (head_g.cnt != '0);
    assign o_out_byte  = o_has_byte ? head_g.bytes[r_idx] : 8'h00;
    assign last        = !o_has_byte || (r_idx == head_g.cnt - scs_pkg::CNT_W'(1));
    assign o_end_of_text = head_g.final_mark && last;

    assign out_take = o_out_valid && !i_out_stall;
    assign pop      = out_take && last;
    assign push     = i_push.push && o_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_count <= 2'd0;
            r_idx   <= '0;
        end else begin
            if (push) begin
                r_tail <= !r_tail;
            end
            if (pop) begin
                r_head <= !r_head;
                r_idx  <= '0;
            end else if (out_take) begin
                r_idx <= r_idx + scs_pkg::CNT_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entries[r_tail] <= i_push.group;
        end
    end

endmodule

`default_nettype wire

// ===== src/c_source_splice_comment_strip_top.sv =====
// Cleans C source text: drops backslash-newline pairs, strips line and block
// comments, and squeezes whitespace runs. One byte is accepted per cycle while
// the two-entry result queue has room; each result leaves through the output
// port in a transaction of its own, and an item causes from 0 to 3 results.
// The input register feeds the splice and strip logic, whose results enter the
// queue in the same cycle; the output is read from the queue entries.
// Depends on scs_pkg, scs_core and scs_outq.
`default_nettype none

module c_source_splice_comment_strip_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire logic [7:0]     i_text_byte,
    input  wire logic           i_final_byte,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_has_byte,
    output logic                o_end_of_text
);

    scs_pkg::t_push     push;
    logic               q_ready;

    scs_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .o_in_stall   (o_in_stall),
        .i_q_ready    (q_ready),
        .o_push       (push)
    );

    scs_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_q_ready     (q_ready),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_has_byte    (o_has_byte),
        .o_end_of_text (o_end_of_text)
    );

endmodule

`default_nettype wire

// ===== src/scs_checker.sv =====
// Port-level checks for the source splice and comment strip top level,
// attached by the bind statement at the end. No package dependencies.
`default_nettype none

module scs_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           o_out_valid,
    input  wire logic           i_out_stall,
    input  wire logic [7:0]     o_out_byte,
    input  wire logic           o_has_byte,
    input  wire logic           o_end_of_text
);

    a_idle_after_reset: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_out_valid
    ) else $error("Output valid right after reset.");

    a_bare_is_end: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_byte) |-> o_end_of_text
    ) else $error("Bare result without end of text.");

    a_bare_is_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_byte) |-> (o_out_byte == 8'h00)
    ) else $error("Bare result carries a nonzero byte.");

    a_stall_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_byte) && $stable(o_has_byte)
             && $stable(o_end_of_text))
    ) else $error("Stalled output transaction changed.");

endmodule

bind c_source_splice_comment_strip_top scs_checker u_scs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_byte    (o_out_byte),
    .o_has_byte    (o_has_byte),
    .o_end_of_text (o_end_of_text)
);

`default_nettype wire
